@@ hdl/gn2d_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn2d_pkg
// shared widths, hash constants and the gradient table builder for the
// 2d gradient noise unit
// ----------------------------------------------------------------------------
package gn2d_pkg;

    localparam int COORD_W              = 24;
    localparam int OUT_W                = 16;
    localparam int GRAD_W               = 16;
    localparam int HASH_W               = 32;
    localparam int FADE_W               = 22;
    localparam int FADE_FRAC            = 16;
    localparam int FRACTION_BITS_DEF    = 12;
    localparam int ANGLE_TABLE_BITS_DEF = 10;
    localparam int TAYLOR_TERMS         = 14;

    localparam logic [HASH_W-1:0] HASH_MUL_A = 32'd3284157443;
    localparam logic [HASH_W-1:0] HASH_MUL_B = 32'd1911520717;
    localparam logic [HASH_W-1:0] HASH_MUL_C = 32'd2048419325;

    // fade polynomial constants in q6.16
    localparam logic signed [FADE_W-1:0] FADE_C15 = 22'sd983040;
    localparam logic signed [FADE_W-1:0] FADE_C10 = 22'sd655360;

    localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
    localparam logic [63:0] ONE_Q60 = 64'h1000000000000000;

    typedef logic [2*GRAD_W-1:0] grad_pair_t;

    // (a*b) >> 60 with a full product
    function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[123:60];
    endfunction

    function automatic logic [GRAD_W-1:0] to_q15(input logic [63:0] v);
        logic [63:0] t;
        t = (v >> 20) * 64'd32767 + (64'd1 << 39);
        return GRAD_W'(t >> 40);
    endfunction

    // {cos, sin} of 2*pi*k/2^abits for k up to one eighth circle, q1.15
    function automatic grad_pair_t octant_entry(input int unsigned k, input int unsigned abits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] csum;
        logic [63:0] cterm;
        logic [63:0] ssum;
        logic [63:0] sterm;
        x     = (PI_Q60 >> (abits - 1)) * 64'(k);
        x2    = mul_q60(x, x);
        csum  = ONE_Q60;
        cterm = ONE_Q60;
        ssum  = x;
        sterm = x;
        for (int unsigned n = 1; n <= TAYLOR_TERMS; n++)
        begin
            cterm = mul_q60(cterm, x2) / 64'((2 * n - 1) * (2 * n));
            sterm = mul_q60(sterm, x2) / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
            begin
                csum = csum - cterm;
                ssum = ssum - sterm;
            end
            else
            begin
                csum = csum + cterm;
                ssum = ssum + sterm;
            end
        end
        return {to_q15(csum), to_q15(ssum)};
    endfunction

endpackage

@@ hdl/gn2d_corner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn2d_corner
// one lattice corner: hash chain, gradient lookup and dot product, 5 stages
// ----------------------------------------------------------------------------
module gn2d_corner #(
    parameter int FRACTION_BITS    = gn2d_pkg::FRACTION_BITS_DEF,
    parameter int ANGLE_TABLE_BITS = gn2d_pkg::ANGLE_TABLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic [gn2d_pkg::HASH_W-1:0]         ix,
    input  logic [gn2d_pkg::HASH_W-1:0]         iy,
    input  logic signed [FRACTION_BITS:0]       dx,
    input  logic signed [FRACTION_BITS:0]       dy,
    output logic signed [FRACTION_BITS+17:0]    dot
);
    import gn2d_pkg::*;

    localparam int DW      = FRACTION_BITS + 1;
    localparam int NW      = FRACTION_BITS + 18;
    localparam int A       = ANGLE_TABLE_BITS;
    localparam int QUARTER = 1 << (A - 2);
    localparam int OCT_N   = QUARTER / 2 + 1;

    // octant table, built at elaboration
    grad_pair_t oct_tab [OCT_N];
    for (genvar k = 0; k < OCT_N; k++)
    begin : g_oct
        localparam grad_pair_t ENTRY = octant_entry(k, A);
        assign oct_tab[k] = ENTRY;
    end

    logic [HASH_W-1:0] ma_reg, ma_b_reg, mb_reg, ph_reg, iy_a_reg;
    logic signed [DW-1:0] dx_pipe_reg [4];
    logic signed [DW-1:0] dy_pipe_reg [4];
    logic signed [GRAD_W-1:0] gx_reg, gy_reg, gx_next, gy_next;
    logic signed [NW-1:0] dot_reg, dot_next;

    logic [A-1:0]   idx;
    logic [1:0]     quad;
    logic [A-3:0]   rem;
    logic [A-2:0]   mirror;
    logic           fold;
    logic [A-3:0]   oct_idx;
    grad_pair_t     entry;
    logic signed [GRAD_W-1:0] c, s;

    always_comb
    begin
        idx     = ph_reg[HASH_W-1 -: A];
        quad    = idx[A-1:A-2];
        rem     = idx[A-3:0];
        mirror  = (A-1)'(QUARTER) - {1'b0, rem};
        fold    = ({1'b0, rem} > (A-1)'(QUARTER / 2));
        oct_idx = fold ? mirror[A-3:0] : rem;
        entry   = oct_tab[oct_idx];
        // past the octant the cosine and sine trade places
        c = fold ? $signed(entry[GRAD_W-1:0]) : $signed(entry[2*GRAD_W-1:GRAD_W]);
        s = fold ? $signed(entry[2*GRAD_W-1:GRAD_W]) : $signed(entry[GRAD_W-1:0]);
        case (quad)
            2'd0:
            begin
                gx_next = c;
                gy_next = s;
            end
            2'd1:
            begin
                gx_next = -s;
                gy_next = c;
            end
            2'd2:
            begin
                gx_next = -c;
                gy_next = -s;
            end
            default:
            begin
                gx_next = s;
                gy_next = -c;
            end
        endcase
        dot_next = NW'(dx_pipe_reg[3]) * NW'(gx_reg) + NW'(dy_pipe_reg[3]) * NW'(gy_reg);
    end

    always_ff @(posedge clk)
    begin
        ma_reg      <= HASH_W'(ix * HASH_MUL_A);
        iy_a_reg    <= iy;
        mb_reg      <= HASH_W'((iy_a_reg ^ {ma_reg[15:0], ma_reg[31:16]}) * HASH_MUL_B);
        ma_b_reg    <= ma_reg;
        ph_reg      <= HASH_W'((ma_b_reg ^ {mb_reg[15:0], mb_reg[31:16]}) * HASH_MUL_C);
        gx_reg      <= gx_next;
        gy_reg      <= gy_next;
        dot_reg     <= dot_next;
        dx_pipe_reg[0] <= dx;
        dy_pipe_reg[0] <= dy;
        for (int i = 1; i < 4; i++)
        begin
            dx_pipe_reg[i] <= dx_pipe_reg[i-1];
            dy_pipe_reg[i] <= dy_pipe_reg[i-1];
        end
    end

    assign dot = dot_reg;

endmodule

@@ hdl/gradient_noise_2d_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_noise_2d_unit
// 2d gradient noise with quintic fade, one sample per clock
// ----------------------------------------------------------------------------
// usage
//   input word: coord_x, coord_y (signed, FRACTION_BITS fraction bits),
//   taken on a rising edge with start high and busy low. busy never rises,
//   so a new word may be offered in every cycle.
//   result word: noise_value (signed q2.14, saturated) with done high for
//   exactly one cycle, when the word reaches the output register.
//   throughput: one word per clock; nine register stages (input, three hash
//   multiplies, gradient lookup, dot product, x blend, y blend, output),
//   with the fade polynomial running alongside the hash multiplies and gradient lookup.
//   reset: rst_n clears the valid bits only; words in flight are dropped
//   and no done pulse comes out of them.
//   the receiver cannot stall; each result must be taken in its own cycle.
// ----------------------------------------------------------------------------
module gradient_noise_2d_unit #(
    parameter int FRACTION_BITS    = gn2d_pkg::FRACTION_BITS_DEF,
    parameter int ANGLE_TABLE_BITS = gn2d_pkg::ANGLE_TABLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [gn2d_pkg::COORD_W-1:0]   coord_x,
    input  logic signed [gn2d_pkg::COORD_W-1:0]   coord_y,
    output logic                                  done,
    output logic signed [gn2d_pkg::OUT_W-1:0]     noise_value
);
    import gn2d_pkg::*;

    localparam int F   = FRACTION_BITS;
    localparam int DW  = F + 1;
    localparam int NW  = F + 18;
    localparam int BW  = F + 19;
    localparam int VW  = F + 20;
    localparam int LAT = 9;

    // valid bits travel alongside the data
    logic [LAT-1:0] valid_reg, valid_next;

    logic signed [COORD_W-1:0] x_reg, y_reg;

    // lattice cell and offsets
    logic [HASH_W-1:0]    ix0, ix1, iy0, iy1;
    logic [F-1:0]         fx, fy;
    logic signed [DW-1:0] dx_near, dx_far, dy_near, dy_far;
    logic signed [NW-1:0] n00, n10, n01, n11;

    always_comb
    begin
        fx  = x_reg[F-1:0];
        fy  = y_reg[F-1:0];
        ix0 = HASH_W'($signed(x_reg[COORD_W-1:F]));
        iy0 = HASH_W'($signed(y_reg[COORD_W-1:F]));
        ix1 = ix0 + HASH_W'(1);
        iy1 = iy0 + HASH_W'(1);
        dx_near = $signed({1'b0, fx});
        dy_near = $signed({1'b0, fy});
        // fraction minus one is the fraction with the sign bit set
        dx_far  = $signed({1'b1, fx});
        dy_far  = $signed({1'b1, fy});
    end

    gn2d_corner #(.FRACTION_BITS(F), .ANGLE_TABLE_BITS(ANGLE_TABLE_BITS)) u_c00 (
        .clk(clk), .ix(ix0), .iy(iy0), .dx(dx_near), .dy(dy_near), .dot(n00));
    gn2d_corner #(.FRACTION_BITS(F), .ANGLE_TABLE_BITS(ANGLE_TABLE_BITS)) u_c10 (
        .clk(clk), .ix(ix1), .iy(iy0), .dx(dx_far), .dy(dy_near), .dot(n10));
    gn2d_corner #(.FRACTION_BITS(F), .ANGLE_TABLE_BITS(ANGLE_TABLE_BITS)) u_c01 (
        .clk(clk), .ix(ix0), .iy(iy1), .dx(dx_near), .dy(dy_far), .dot(n01));
    gn2d_corner #(.FRACTION_BITS(F), .ANGLE_TABLE_BITS(ANGLE_TABLE_BITS)) u_c11 (
        .clk(clk), .ix(ix1), .iy(iy1), .dx(dx_far), .dy(dy_far), .dot(n11));

    // fade, horner form, one multiply per stage; index 0 is x, 1 is y
    logic [FADE_FRAC-1:0]     w0 [2];
    logic [FADE_FRAC-1:0]     w1_reg [2], w2_reg [2], w3_reg [2];
    logic signed [FADE_W-1:0] fa [2];
    logic signed [FADE_W-1:0] t1_reg [2], c_reg [2], d_reg [2], f_reg [2], f5_reg [2];
    logic signed [FADE_W-1:0] t1_next [2], c_next [2], d_next [2], f_next [2];
    logic signed [39:0]       p1 [2], p2 [2], p3 [2], p4 [2];

    always_comb
    begin
        w0[0] = FADE_FRAC'(fx) << (FADE_FRAC - F);
        w0[1] = FADE_FRAC'(fy) << (FADE_FRAC - F);
        for (int i = 0; i < 2; i++)
        begin
            fa[i]      = $signed({6'd0, w0[i]}) * 22'sd6 - FADE_C15;
            p1[i]      = 40'(fa[i]) * 40'($signed({1'b0, w0[i]}));
            t1_next[i] = FADE_W'(p1[i] >>> FADE_FRAC) + FADE_C10;
            p2[i]      = 40'(t1_reg[i]) * 40'($signed({1'b0, w1_reg[i]}));
            c_next[i]  = FADE_W'(p2[i] >>> FADE_FRAC);
            p3[i]      = 40'(c_reg[i]) * 40'($signed({1'b0, w2_reg[i]}));
            d_next[i]  = FADE_W'(p3[i] >>> FADE_FRAC);
            p4[i]      = 40'(d_reg[i]) * 40'($signed({1'b0, w3_reg[i]}));
            f_next[i]  = FADE_W'(p4[i] >>> FADE_FRAC);
        end
    end

    // blend along x, then along y, then scale and saturate
    logic signed [FADE_W-1:0]   wy6_reg;
    logic signed [BW-1:0]       bx0_reg, bx1_reg, bx0_next, bx1_next;
    logic signed [VW-1:0]       by_reg, by_next;
    logic signed [BW+FADE_W-1:0] px0, px1;
    logic signed [VW+FADE_W-1:0] py;
    logic signed [18:0]         scaled;
    logic signed [OUT_W-1:0]    noise_reg, noise_next;

    always_comb
    begin
        px0      = (BW+FADE_W)'(BW'(n10) - BW'(n00)) * (BW+FADE_W)'(f5_reg[0]);
        px1      = (BW+FADE_W)'(BW'(n11) - BW'(n01)) * (BW+FADE_W)'(f5_reg[0]);
        bx0_next = BW'(n00) + BW'(px0 >>> FADE_FRAC);
        bx1_next = BW'(n01) + BW'(px1 >>> FADE_FRAC);
        py       = (VW+FADE_W)'(VW'(bx1_reg) - VW'(bx0_reg)) * (VW+FADE_W)'(wy6_reg);
        by_next  = VW'(bx0_reg) + VW'(py >>> FADE_FRAC);
        scaled   = 19'(by_reg >>> (F + 1));
        if (scaled > 19'sd32767)
        begin
            noise_next = 16'sd32767;
        end
        else if (scaled < -19'sd32768)
        begin
            noise_next = -16'sd32768;
        end
        else
        begin
            noise_next = OUT_W'(scaled);
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= coord_x;
        y_reg <= coord_y;
        for (int i = 0; i < 2; i++)
        begin
            w1_reg[i] <= w0[i];
            w2_reg[i] <= w1_reg[i];
            w3_reg[i] <= w2_reg[i];
            t1_reg[i] <= t1_next[i];
            c_reg[i]  <= c_next[i];
            d_reg[i]  <= d_next[i];
            f_reg[i]  <= f_next[i];
            f5_reg[i] <= f_reg[i];
        end
        wy6_reg   <= f5_reg[1];
        bx0_reg   <= bx0_next;
        bx1_reg   <= bx1_next;
        by_reg    <= by_next;
        noise_reg <= noise_next;
    end

    // control
    assign busy       = 1'b0;
    assign valid_next = {valid_reg[LAT-2:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign done        = valid_reg[LAT-1];
    assign noise_value = noise_reg;

    // every accepted word later comes out with done high
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("accepted word did not produce a result");

    // no result without an accepted word
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("result without an accepted word");

    // the pipeline never holds off the sender
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

endmodule
